// ----- src/radio_link_retry_fsm_macros.svh -----
// Assertion macros shared by the radio link retry block.
// Needs nothing else; every file that asserts includes this header.
`ifndef RADIO_LINK_RETRY_FSM_MACROS_SVH
`define RADIO_LINK_RETRY_FSM_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define RLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radio link retry: check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define RLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radio link retry: check failed");

`endif

// ----- src/rlr_pkg.sv -----
// Package for the radio link retry block: widths, codes, reset values and
// the structs passed between its modules. Depends on nothing.
package rlr_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_TIME_WIDTH  = 32;
    localparam int DEF_COUNT_WIDTH = 16;

    // Fixed field widths.
    localparam int OP_W    = 2;
    localparam int NOW_W   = 32;
    localparam int KIND_W  = 3;
    localparam int STATE_W = 3;
    localparam int SEND_W  = 3;
    localparam int PKT_W   = 16;
    localparam int DLY_W   = 16;

    // Configuration port.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic REG_RESEND_WAIT = 1'b0;
    localparam logic REG_ACK_WAIT    = 1'b1;
    localparam logic [DLY_W-1:0] RESEND_WAIT_RST = 16'd2500;
    localparam logic [DLY_W-1:0] ACK_WAIT_RST    = 16'd5000;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_PACKET = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    // Received packet kinds.
    localparam logic [KIND_W-1:0] KIND_PING   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PONG   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SENSOR = 3'd3;

    // Protocol states.
    typedef enum logic [STATE_W-1:0] {
        ST_ENQUEUE     = 3'd0,
        ST_PING        = 3'd1,
        ST_LISTEN_PONG = 3'd2,
        ST_LISTEN_ACK  = 3'd3,
        ST_BREAK       = 3'd4,
        ST_NOBODY      = 3'd5,
        ST_EMPTY       = 3'd6
    } t_state;

    // Frames sent on the radio.
    typedef enum logic [SEND_W-1:0] {
        SEND_NONE   = 3'd0,
        SEND_PING   = 3'd1,
        SEND_PONG   = 3'd2,
        SEND_ACK    = 3'd3,
        SEND_RECORD = 3'd4,
        SEND_RESEND = 3'd5
    } t_send;

    // One input transaction.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [NOW_W-1:0]   now_ms;
        logic [KIND_W-1:0]  kind;
        logic               granted;
        logic               has_item;
        logic [STATE_W-1:0] start;
    } t_item;

    // One result transaction.
    typedef struct packed {
        t_send             send;
        logic              pop;
        logic              rewind;
        logic              sleep;
        t_state            state;
        logic [PKT_W-1:0]  count;
    } t_result;

    // Configuration values seen by the protocol core.
    typedef struct packed {
        logic [DLY_W-1:0] resend_wait;
        logic [DLY_W-1:0] ack_wait;
    } t_cfg;

endpackage

// ----- src/rlr_cfg.sv -----
// APB-style register file for the radio link retry block.
// Depends on rlr_pkg for addresses, widths and reset values.
module rlr_cfg
    import rlr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [DLY_W-1:0] r_resend_wait;
    logic [DLY_W-1:0] r_ack_wait;
    logic             w_wr;
    logic             w_idx;

    // Register index is the word address; the port never stalls.
    assign w_idx  = paddr[2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resend_wait <= RESEND_WAIT_RST;
            r_ack_wait    <= ACK_WAIT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_RESEND_WAIT: r_resend_wait <= pwdata[DLY_W-1:0];
                REG_ACK_WAIT:    r_ack_wait    <= pwdata[DLY_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data, zero above the register width.
    always_comb begin
        case (w_idx)
            REG_RESEND_WAIT: prdata = APB_DW'(r_resend_wait);
            REG_ACK_WAIT:    prdata = APB_DW'(r_ack_wait);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.resend_wait = r_resend_wait;
    assign o_cfg.ack_wait    = r_ack_wait;

endmodule

// ----- src/rlr_core.sv -----
// Protocol core: state, delay timer and packet counter with their
// next-state logic. Depends on rlr_pkg for codes, types and widths.
module rlr_core
    import rlr_pkg::*;
#(
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_state                  r_state,  n_state;
    logic [DLY_W-1:0]        r_dlen,   n_dlen;
    logic [TIME_WIDTH-1:0]   r_dstart, n_dstart;
    logic [COUNT_WIDTH-1:0]  r_cnt,    n_cnt;

    logic [TIME_WIDTH+NOW_W-1:0]  w_now_ext;
    logic [TIME_WIDTH-1:0]        w_now;
    logic [TIME_WIDTH-1:0]        w_elapsed;
    logic                         w_in_delay;
    logic                         w_listening;

    // Clock value reduced to the timer width.
    assign w_now_ext = {{TIME_WIDTH{1'b0}}, i_item.now_ms};
    assign w_now     = w_now_ext[TIME_WIDTH-1:0];

    // A delay runs while it is set and the elapsed time is below its length.
    assign w_elapsed   = w_now - r_dstart;
    assign w_in_delay  = (r_dlen != '0) && (w_elapsed < TIME_WIDTH'(r_dlen));
    assign w_listening = r_state inside {ST_LISTEN_PONG, ST_LISTEN_ACK};

    // State registers advance only when a transaction is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_ENQUEUE;
            r_dlen   <= '0;
            r_dstart <= '0;
            r_cnt    <= '0;
        end else if (i_fire) begin
            r_state  <= n_state;
            r_dlen   <= n_dlen;
            r_dstart <= n_dstart;
            r_cnt    <= n_cnt;
        end
    end

    // Next state and result flags for the transaction at hand.
    always_comb begin
        n_state         = r_state;
        n_dlen          = r_dlen;
        n_dstart        = r_dstart;
        n_cnt           = r_cnt;
        o_result.send   = SEND_NONE;
        o_result.pop    = 1'b0;
        o_result.rewind = 1'b0;
        o_result.sleep  = 1'b0;

        case (i_item.op)
            OP_TICK: begin
                // An expired delay is cleared and its start follows the clock.
                if (!w_in_delay) begin
                    n_dlen   = '0;
                    n_dstart = w_now;
                end
                case (r_state)
                    ST_PING: begin
                        o_result.send = SEND_PING;
                        n_state  = ST_LISTEN_PONG;
                        n_dlen   = i_cfg.resend_wait;
                        n_dstart = w_now;
                    end
                    ST_LISTEN_ACK: begin
                        if (!w_in_delay) begin
                            if (i_item.granted) begin
                                o_result.send = SEND_RESEND;
                                n_state = ST_LISTEN_ACK;
                            end else begin
                                n_state = ST_BREAK;
                            end
                            n_dlen   = i_cfg.resend_wait;
                            n_dstart = w_now;
                        end
                    end
                    ST_LISTEN_PONG: begin
                        if (!w_in_delay) begin
                            if (i_item.granted) begin
                                o_result.send = SEND_RESEND;
                                n_state = ST_LISTEN_PONG;
                                n_dlen  = i_cfg.resend_wait;
                            end else begin
                                o_result.sleep = 1'b1;
                                n_state = ST_NOBODY;
                                n_dlen  = '0;
                            end
                            n_dstart = w_now;
                        end
                    end
                    ST_BREAK: begin
                        if (!w_in_delay) begin
                            n_state  = ST_PING;
                            n_dlen   = '0;
                            n_dstart = w_now;
                        end
                    end
                    default: ;
                endcase
            end
            OP_PACKET: begin
                // Packets count only in the polling states.
                if (r_state == ST_ENQUEUE || (w_listening && w_in_delay)) begin
                    n_cnt = r_cnt + 1'b1;
                    case (i_item.kind)
                        KIND_PING: o_result.send = SEND_PONG;
                        KIND_PONG, KIND_ACK: begin
                            if ((i_item.kind == KIND_ACK && w_listening) ||
                                r_state == ST_LISTEN_PONG) begin
                                o_result.rewind = (i_item.kind == KIND_PONG);
                                // Send the next queued record, or sleep when empty.
                                if (i_item.has_item) begin
                                    o_result.send = SEND_RECORD;
                                    o_result.pop  = 1'b1;
                                    n_state = ST_LISTEN_ACK;
                                    n_dlen  = i_cfg.ack_wait;
                                end else begin
                                    o_result.sleep = 1'b1;
                                    n_state = ST_EMPTY;
                                    n_dlen  = '0;
                                end
                                n_dstart = w_now;
                            end
                        end
                        KIND_SENSOR: begin
                            if (r_state == ST_ENQUEUE) begin
                                o_result.send = SEND_ACK;
                            end
                        end
                        default: o_result.send = SEND_ACK;
                    endcase
                end
            end
            OP_START: begin
                // Start over in the requested state, saturated to the last code.
                if (i_item.start > STATE_W'(ST_EMPTY)) begin
                    n_state = ST_EMPTY;
                end else begin
                    n_state = t_state'(i_item.start);
                end
                n_cnt    = '0;
                n_dlen   = '0;
                n_dstart = w_now;
            end
            default: ;
        endcase

        // Reported count is the low bits of the counter.
        o_result.state = n_state;
        o_result.count = PKT_W'(n_cnt);
    end

endmodule

// ----- src/radio_link_retry_fsm.sv -----
// Top level of the radio link retry block: input register, protocol core,
// result register and configuration port. Depends on rlr_pkg, rlr_cfg,
// rlr_core and radio_link_retry_fsm_macros.svh.
//
// Usage: each input transaction (i_valid/o_ready) is a time tick, a received
// packet or a start-over request. Every accepted transaction yields exactly
// one result transaction (o_valid/i_ready) with the frame to send, the queue
// and sleep flags, the protocol state after the transaction and the packet
// count.
// An accepted transaction passes through the input register and then the
// result register before o_valid rises. Throughput is one transaction per
// cycle while the receiver takes results (i_ready high).
// When the receiver stalls, the result register holds its transaction and
// the input register holds one more; o_ready drops only when both are full.
// Reset (synchronous, active low) clears both registers, puts the protocol
// in the enqueue state with no delay and a zero count, and loads the delay
// registers with 2500 ms (retry) and 5000 ms (ack wait).
// Registers on the APB port: resend_wait at 0x0, ack_wait at 0x4. They must
// be written only while no transaction is in flight; the block does not enforce it.
`include "radio_link_retry_fsm_macros.svh"

module radio_link_retry_fsm
    import rlr_pkg::*;
#(
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [NOW_W-1:0]   i_now_ms,
    input  logic [KIND_W-1:0]  i_packet_kind,
    input  logic               i_resend_granted,
    input  logic               i_queue_has_item,
    input  logic [STATE_W-1:0] i_start_state,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SEND_W-1:0]  o_send_kind,
    output logic               o_queue_pop,
    output logic               o_queue_rewind,
    output logic               o_radio_sleep,
    output logic [STATE_W-1:0] o_state_now,
    output logic [PKT_W-1:0]   o_packets_received,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    w_adv;
    t_cfg    w_cfg;
    t_result w_res;

    // The held transaction moves on when the result register is free.
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in.op       <= i_operation;
            r_in.now_ms   <= i_now_ms;
            r_in.kind     <= i_packet_kind;
            r_in.granted  <= i_resend_granted;
            r_in.has_item <= i_queue_has_item;
            r_in.start    <= i_start_state;
        end
    end

    // Configuration registers.
    rlr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Protocol state and next-state logic.
    rlr_core #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_send_kind        = r_out.send;
    assign o_queue_pop        = r_out.pop;
    assign o_queue_rewind     = r_out.rewind;
    assign o_radio_sleep      = r_out.sleep;
    assign o_state_now        = r_out.state;
    assign o_packets_received = r_out.count;

    // A processed transaction always lands in the result register.
    `RLR_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    // A held transaction is never lost while the result side is stalled.
    `RLR_ASSERT_NEXT(a_in_kept, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid)
    // A queue pop always goes with sending the queued record.
    `RLR_ASSERT_NOW(a_pop_record, i_clk, i_rst_n, r_out_valid && r_out.pop,
        r_out.send == SEND_RECORD)
    // Sleep only when entering a state where nobody answers or the queue is empty.
    `RLR_ASSERT_NOW(a_sleep_state, i_clk, i_rst_n, r_out_valid && r_out.sleep,
        r_out.state == ST_NOBODY || r_out.state == ST_EMPTY)

endmodule
